// File: src/rme_pkg.sv
// Package for the RSA modular exponentiation element cipher.
// Holds the field widths, register indexes, controller states and the multiplier status type.
// No dependencies; every other file in src uses it by scoped names.
package rme_pkg;

    // Fixed field widths of the interface.
    localparam int VALUE_BITS    = 32;
    localparam int RESULT_BITS   = 32;
    localparam int EXP_BITS      = 32;
    localparam int EXP_CNT_BITS  = $clog2(EXP_BITS);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int BYTE_BITS     = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUBLIC_EXP  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIVATE_EXP = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS     = 2'd2;

    // Item modes.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Exponentiation controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE_GO,
        ST_REDUCE_WAIT,
        ST_SQUARE_GO,
        ST_SQUARE_WAIT,
        ST_MULT_GO,
        ST_MULT_WAIT,
        ST_FINISH
    } state_t;

    // Status reported by the bit-serial modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// File: src/rme_mulmod.sv
// Bit-serial modular multiplier: product = (op_a * op_b) mod modulus, one bit of op_b per cycle.
// Requires op_a < modulus and modulus > 0; op_b may take any value.
// Depends on rme_pkg for the status type.
module rme_mulmod #(
    parameter int MOD_BITS = 32,
    parameter int OP_BITS  = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [MOD_BITS-1:0]     op_a,
    input  logic [OP_BITS-1:0]      op_b,
    input  logic [MOD_BITS-1:0]     modulus,
    output rme_pkg::mm_status_t     status,
    output logic [MOD_BITS-1:0]     product
);

    localparam int EXT_BITS = MOD_BITS + 3;
    localparam int CNT_BITS = $clog2(OP_BITS + 1);

    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] a_reg, a_next;
    logic [MOD_BITS-1:0] m_reg, m_next;
    logic [OP_BITS-1:0]  b_reg, b_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [EXT_BITS-1:0] acc_dbl;
    logic [EXT_BITS-1:0] a_ext;
    logic [EXT_BITS-1:0] m_ext;
    logic [EXT_BITS-1:0] sum_ext;
    logic [EXT_BITS-1:0] diff1;
    logic [EXT_BITS-1:0] diff2;
    logic [MOD_BITS-1:0] step_val;

    // One step: acc = (2*acc + bit*a) mod m. The sum stays below 3m, so at most two
    // subtractions of m are needed; both are formed in parallel and the sign bits select.
    always_comb begin
        acc_dbl = {2'b00, acc_reg, 1'b0};
        a_ext   = {3'b000, a_reg};
        m_ext   = {3'b000, m_reg};
        sum_ext = acc_dbl + (b_reg[OP_BITS-1] ? a_ext : '0);
        diff1   = sum_ext - m_ext;
        diff2   = sum_ext - {m_ext[EXT_BITS-2:0], 1'b0};
        if (!diff2[EXT_BITS-1]) begin
            step_val = diff2[MOD_BITS-1:0];
        end else if (!diff1[EXT_BITS-1]) begin
            step_val = diff1[MOD_BITS-1:0];
        end else begin
            step_val = sum_ext[MOD_BITS-1:0];
        end
    end

    // Operand load, multiplier-bit shift register and step counter.
    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        m_next    = m_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            a_next    = op_a;
            m_next    = modulus;
            b_next    = op_b;
            cnt_next  = CNT_BITS'(OP_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = step_val;
            b_next   = {b_reg[OP_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flops are reset; the datapath flops are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        m_reg   <= m_next;
        b_reg   <= b_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

// File: src/rsa_modexp_element_cipher.sv
// Channel   | Direction | Handshake        | Payload
// cfg       | in        | cfg_we           | cfg_index, cfg_wdata
// s (items) | in        | s_valid/s_ready  | s_mode, s_value, s_last_in
// m (result)| out       | m_valid/m_ready  | m_result, m_last_out
//
// One item at a time. Each item takes (33 + popcount(exponent)) modular multiplies in the
// bit-serial multiplier (OP_BITS = max(MOD_BITS, 32)): one reduction, one square per
// exponent bit and one multiply per set exponent bit.
// A modulus of zero gives result 0 without running the multiplier.
// Reset is synchronous and active low; it clears the controller and the output valid.
// A finished result waits in the output register while the next transaction is accepted.
// Top level: square-and-multiply controller around rme_mulmod; depends on rme_pkg.
module rsa_modexp_element_cipher #(
    parameter int MOD_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [rme_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [rme_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_mode,
    input  logic [rme_pkg::VALUE_BITS-1:0]       s_value,
    input  logic                                 s_last_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rme_pkg::RESULT_BITS-1:0]      m_result,
    output logic                                 m_last_out
);

    localparam int OP_BITS = (MOD_BITS > rme_pkg::VALUE_BITS) ? MOD_BITS : rme_pkg::VALUE_BITS;

    rme_pkg::state_t state_reg, state_next;

    logic [rme_pkg::EXP_BITS-1:0]      pub_exp_reg;
    logic [rme_pkg::EXP_BITS-1:0]      priv_exp_reg;
    logic [rme_pkg::CFG_DATA_BITS-1:0] modulus_reg;

    logic [rme_pkg::EXP_BITS-1:0]     exp_reg, exp_next;
    logic [rme_pkg::EXP_CNT_BITS-1:0] bit_cnt_reg, bit_cnt_next;
    logic [OP_BITS-1:0]               value_reg, value_next;
    logic [MOD_BITS-1:0]              base_reg, base_next;
    logic [MOD_BITS-1:0]              acc_reg, acc_next;
    logic                             mode_reg, mode_next;
    logic                             last_reg, last_next;

    logic                             m_valid_reg, m_valid_next;
    logic [rme_pkg::RESULT_BITS-1:0]  result_reg, result_next;
    logic                             last_out_reg, last_out_next;

    logic [OP_BITS-1:0]  mod_wide;
    logic [MOD_BITS-1:0] mod_eff;
    logic                mod_zero;
    logic [MOD_BITS-1:0] one_val;
    logic [OP_BITS-1:0]  acc_wide;
    logic [rme_pkg::RESULT_BITS-1:0] acc_result;

    logic                 in_fire;
    logic                 out_free;
    logic                 last_bit;

    logic                 mul_start;
    logic [MOD_BITS-1:0]  mul_a;
    logic [OP_BITS-1:0]   mul_b;
    rme_pkg::mm_status_t  mul_status;
    logic [MOD_BITS-1:0]  mul_product;

    // Effective modulus, cut or extended to MOD_BITS, 1 mod m, and the result word (low byte in decrypt mode).
    always_comb begin
        mod_wide = OP_BITS'(modulus_reg);
        mod_eff  = mod_wide[MOD_BITS-1:0];
        mod_zero = (mod_eff == '0);
        one_val  = {{(MOD_BITS-1){1'b0}}, (mod_eff != MOD_BITS'(1))};
        acc_wide = OP_BITS'(acc_reg);
        if (mode_reg == rme_pkg::MODE_DECRYPT) begin
            acc_result = {{(rme_pkg::RESULT_BITS-rme_pkg::BYTE_BITS){1'b0}},
                          acc_wide[rme_pkg::BYTE_BITS-1:0]};
        end else begin
            acc_result = acc_wide[rme_pkg::RESULT_BITS-1:0];
        end
    end

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_bit = (bit_cnt_reg == '0);

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pub_exp_reg  <= '0;
            priv_exp_reg <= '0;
            modulus_reg  <= rme_pkg::CFG_DATA_BITS'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                rme_pkg::CFG_PUBLIC_EXP:  pub_exp_reg  <= cfg_wdata;
                rme_pkg::CFG_PRIVATE_EXP: priv_exp_reg <= cfg_wdata;
                rme_pkg::CFG_MODULUS:     modulus_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state of the square-and-multiply sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rme_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = mod_zero ? rme_pkg::ST_FINISH : rme_pkg::ST_REDUCE_GO;
                end
            end
            rme_pkg::ST_REDUCE_GO:  state_next = rme_pkg::ST_REDUCE_WAIT;
            rme_pkg::ST_REDUCE_WAIT: begin
                if (mul_status.done) begin
                    state_next = rme_pkg::ST_SQUARE_GO;
                end
            end
            rme_pkg::ST_SQUARE_GO:  state_next = rme_pkg::ST_SQUARE_WAIT;
            rme_pkg::ST_SQUARE_WAIT: begin
                if (mul_status.done) begin
                    if (exp_reg[rme_pkg::EXP_BITS-1]) begin
                        state_next = rme_pkg::ST_MULT_GO;
                    end else if (last_bit) begin
                        state_next = rme_pkg::ST_FINISH;
                    end else begin
                        state_next = rme_pkg::ST_SQUARE_GO;
                    end
                end
            end
            rme_pkg::ST_MULT_GO:    state_next = rme_pkg::ST_MULT_WAIT;
            rme_pkg::ST_MULT_WAIT: begin
                if (mul_status.done) begin
                    state_next = last_bit ? rme_pkg::ST_FINISH : rme_pkg::ST_SQUARE_GO;
                end
            end
            rme_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rme_pkg::ST_IDLE;
                end
            end
            default: state_next = rme_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: input ready, multiplier operands, and datapath and output register updates.
    always_comb begin
        s_ready       = (state_reg == rme_pkg::ST_IDLE);
        mul_start     = 1'b0;
        mul_a         = acc_reg;
        mul_b         = OP_BITS'(acc_reg);
        exp_next      = exp_reg;
        bit_cnt_next  = bit_cnt_reg;
        value_next    = value_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        mode_next     = mode_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        result_next   = result_reg;
        last_out_next = last_out_reg;
        case (state_reg)
            rme_pkg::ST_IDLE: begin
                if (in_fire) begin
                    mode_next    = s_mode;
                    last_next    = s_last_in;
                    value_next   = OP_BITS'(s_value);
                    exp_next     = (s_mode == rme_pkg::MODE_DECRYPT) ? priv_exp_reg
                                                                     : pub_exp_reg;
                    bit_cnt_next = rme_pkg::EXP_CNT_BITS'(rme_pkg::EXP_BITS - 1);
                    acc_next     = '0;
                end
            end
            // Reduce the input value: (1 mod m) * value mod m.
            rme_pkg::ST_REDUCE_GO: begin
                mul_start = 1'b1;
                mul_a     = one_val;
                mul_b     = value_reg;
            end
            rme_pkg::ST_REDUCE_WAIT: begin
                if (mul_status.done) begin
                    base_next = mul_product;
                    acc_next  = one_val;
                end
            end
            rme_pkg::ST_SQUARE_GO: begin
                mul_start = 1'b1;
                mul_a     = acc_reg;
                mul_b     = OP_BITS'(acc_reg);
            end
            rme_pkg::ST_SQUARE_WAIT: begin
                if (mul_status.done) begin
                    acc_next = mul_product;
                    if (!exp_reg[rme_pkg::EXP_BITS-1]) begin
                        exp_next     = {exp_reg[rme_pkg::EXP_BITS-2:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg - rme_pkg::EXP_CNT_BITS'(1);
                    end
                end
            end
            rme_pkg::ST_MULT_GO: begin
                mul_start = 1'b1;
                mul_a     = acc_reg;
                mul_b     = OP_BITS'(base_reg);
            end
            rme_pkg::ST_MULT_WAIT: begin
                if (mul_status.done) begin
                    acc_next     = mul_product;
                    exp_next     = {exp_reg[rme_pkg::EXP_BITS-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - rme_pkg::EXP_CNT_BITS'(1);
                end
            end
            // Hand the result to the output register once it is free.
            rme_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    result_next   = acc_result;
                    last_out_next = last_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rme_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bit_cnt_reg <= bit_cnt_next;
        end
        exp_reg      <= exp_next;
        value_reg    <= value_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        mode_reg     <= mode_next;
        last_reg     <= last_next;
        result_reg   <= result_next;
        last_out_reg <= last_out_next;
    end

    rme_mulmod #(
        .MOD_BITS (MOD_BITS),
        .OP_BITS  (OP_BITS)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_eff),
        .status  (mul_status),
        .product (mul_product)
    );

    assign m_valid    = m_valid_reg;
    assign m_result   = result_reg;
    assign m_last_out = last_out_reg;

endmodule

// File: src/rme_checker.sv
// Port-level checker for rsa_modexp_element_cipher, attached by the bind below.
// Depends on rme_pkg for port widths.
module rme_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [rme_pkg::RESULT_BITS-1:0]    m_result,
    input logic                               m_last_out
);

    // The output is empty in the first cycle after reset.
    assert property (@(posedge aclk) $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result) && $stable(m_last_out)))
        else $error("stalled result changed");

    // Only one transaction is in work: input closes right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction is in work");

    // No result can appear in the cycle right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared too early");

endmodule

bind rsa_modexp_element_cipher rme_checker u_rme_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_result   (m_result),
    .m_last_out (m_last_out)
);
